/* hdl/mld_pkg.sv */
// ----------------------------------------------------------------------------
// mld_pkg: shared types and constants of the magic/length deframer
// Phase and status codes, register indexes, reset values and result type.
// ----------------------------------------------------------------------------
package mld_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned LEN_W       = 32;

    localparam int unsigned DEF_SYNC_BYTES   = 4;
    localparam int unsigned DEF_LENGTH_BYTES = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_WORD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN   = 8'd1;

    localparam logic [CFG_DATA_W-1:0] RST_SYNC_WORD = 32'hCA6E_E595;
    localparam logic [CFG_DATA_W-1:0] RST_MAX_LEN   = 32'd65535;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_ABORT    = 2'd1,
        ST_OVERSIZE = 2'd2
    } t_status;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] sync_word;
        logic [LEN_W-1:0]      max_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_last;
        t_status    status;
    } t_result;

endpackage

/* hdl/mld_if.sv */
// ----------------------------------------------------------------------------
// mld_if: channel interfaces of the deframer
// Byte input stream, result output stream and register write channel.
// ----------------------------------------------------------------------------
interface mld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       body_end;

    modport source (output valid, output in_byte, output body_end, input ready);
    modport sink   (input valid, input in_byte, input body_end, output ready);
endinterface

interface mld_out_if;
    logic             valid;
    logic             ready;
    logic [7:0]       payload_byte;
    logic             frame_last;
    mld_pkg::t_status status;

    modport source (output valid, output payload_byte, output frame_last,
                    output status, input ready);
    modport sink   (input valid, input payload_byte, input frame_last,
                    input status, output ready);
endinterface

interface mld_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mld_pkg::CFG_INDEX_W-1:0]  index;
    logic [mld_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/mld_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mld_cfg_regs: configuration registers
// Holds the sync word and the payload length limit; writes always accepted.
// ----------------------------------------------------------------------------
module mld_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mld_cfg_if.sink        i_cfg,
    output mld_pkg::t_cfg  o_cfg
);

    mld_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_word <= mld_pkg::RST_SYNC_WORD;
            r_cfg.max_len   <= mld_pkg::RST_MAX_LEN;
        end else if (i_cfg.valid) begin
            // ignore writes to indexes beyond the register list
            if (i_cfg.index == mld_pkg::REG_SYNC_WORD) begin
                r_cfg.sync_word <= i_cfg.data;
            end else if (i_cfg.index == mld_pkg::REG_MAX_LEN) begin
                r_cfg.max_len <= i_cfg.data;
            end
        end
    end

endmodule

/* hdl/mld_core.sv */
// ----------------------------------------------------------------------------
// mld_core: frame state machine
// Hunts the sync word, gathers the length and forwards payload bytes.
// ----------------------------------------------------------------------------
module mld_core #(
    parameter int unsigned SYNC_BYTES   = mld_pkg::DEF_SYNC_BYTES,
    parameter int unsigned LENGTH_BYTES = mld_pkg::DEF_LENGTH_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mld_pkg::t_cfg    i_cfg,
    mld_in_if.sink           i_in,
    input  logic             i_res_room,
    output logic             o_res_valid,
    output mld_pkg::t_result o_res
);

    localparam int unsigned SW    = 8 * SYNC_BYTES;
    localparam int unsigned CNT_W = $clog2(SYNC_BYTES + 1);
    localparam int unsigned LBS_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SYNC_BYTES);
    localparam logic [LBS_W-1:0] LBS_LAST = LBS_W'(LENGTH_BYTES - 1);
    localparam int unsigned LW    = mld_pkg::LEN_W;

    mld_pkg::t_phase r_phase, n_phase;
    logic [SW-1:0]    r_recent, n_recent;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LBS_W-1:0] r_lbs, n_lbs;
    logic [LW-1:0]    r_rem, n_rem;

    logic                    accept;
    logic [SW+31:0]          sync_wide;
    logic [SW-1:0]           sync_cmp;
    logic [LW-1:0]           len_next;

    assign i_in.ready = i_res_room;
    assign accept     = i_in.valid && i_res_room;

    // sync bytes above the 32-bit register compare as zero
    assign sync_wide = {{SW{1'b0}}, i_cfg.sync_word};
    assign sync_cmp  = sync_wide[SW-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_recent    = r_recent;
        n_count     = r_count;
        n_lbs       = r_lbs;
        n_rem       = r_rem;
        len_next    = {r_rem[LW-9:0], i_in.in_byte};
        o_res_valid = 1'b0;
        o_res       = '{payload_byte: 8'd0, frame_last: 1'b0,
                        status: mld_pkg::ST_DATA};

        if (accept) begin
            if (i_in.body_end) begin
                // abort any frame in progress, restart the hunt
                if (r_phase == mld_pkg::PH_LEN || r_phase == mld_pkg::PH_DATA) begin
                    o_res_valid  = 1'b1;
                    o_res.status = mld_pkg::ST_ABORT;
                end
                n_phase  = mld_pkg::PH_HUNT;
                n_recent = '0;
                n_count  = '0;
                n_lbs    = '0;
                n_rem    = '0;
            end else begin
                case (r_phase)
                    mld_pkg::PH_LEN: begin
                        n_rem = len_next;
                        if (r_lbs == LBS_LAST) begin
                            n_lbs = '0;
                            if (len_next == '0) begin
                                n_phase = mld_pkg::PH_HUNT;
                            end else if (len_next > i_cfg.max_len) begin
                                n_phase      = mld_pkg::PH_HUNT;
                                n_rem        = '0;
                                o_res_valid  = 1'b1;
                                o_res.status = mld_pkg::ST_OVERSIZE;
                            end else begin
                                n_phase = mld_pkg::PH_DATA;
                            end
                        end else begin
                            n_lbs = r_lbs + 1'b1;
                        end
                    end
                    mld_pkg::PH_DATA: begin
                        n_rem              = r_rem - 1'b1;
                        o_res_valid        = 1'b1;
                        o_res.payload_byte = i_in.in_byte;
                        if (r_rem == LW'(1)) begin
                            o_res.frame_last = 1'b1;
                            n_phase          = mld_pkg::PH_HUNT;
                            n_rem            = '0;
                        end
                    end
                    default: begin
                        n_phase = mld_pkg::PH_HUNT;
                        n_recent = SW'({r_recent, i_in.in_byte});
                        if (r_count != CNT_FULL) begin
                            n_count = r_count + 1'b1;
                        end
                        if (n_count == CNT_FULL && n_recent == sync_cmp) begin
                            n_recent = '0;
                            n_count  = '0;
                            n_phase  = mld_pkg::PH_LEN;
                            n_lbs    = '0;
                            n_rem    = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mld_pkg::PH_HUNT;
            r_recent <= '0;
            r_count  <= '0;
            r_lbs    <= '0;
            r_rem    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_count  <= n_count;
            r_lbs    <= n_lbs;
            r_rem    <= n_rem;
        end
    end

endmodule

/* hdl/mld_out_buf.sv */
// ----------------------------------------------------------------------------
// mld_out_buf: result register with skid stage
// Two-entry output buffer so the input side keeps moving while a result waits.
// ----------------------------------------------------------------------------
module mld_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mld_pkg::t_result i_res,
    output logic             o_room,
    mld_out_if.source        o_out
);

    logic             r_main_v, n_main_v;
    logic             r_skid_v, n_skid_v;
    mld_pkg::t_result r_main, n_main;
    mld_pkg::t_result r_skid, n_skid;
    logic             pop;

    assign o_room             = !r_skid_v;
    assign pop                = r_main_v && o_out.ready;
    assign o_out.valid        = r_main_v;
    assign o_out.payload_byte = r_main.payload_byte;
    assign o_out.frame_last   = r_main.frame_last;
    assign o_out.status       = r_main.status;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (pop) begin
            if (r_skid_v) begin
                // advance the skid entry; no push can arrive while it is full
                n_main   = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_main_v = i_push;
                n_main   = i_res;
            end
        end else if (i_push) begin
            if (!r_main_v) begin
                n_main_v = 1'b1;
                n_main   = i_res;
            end else begin
                n_skid_v = 1'b1;
                n_skid   = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

/* hdl/magic_length_deframer.sv */
// ----------------------------------------------------------------------------
// magic_length_deframer: sync-word hunting, length-prefixed deframer
// Top level: configuration registers, frame state machine, output buffer.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one body byte per item with a body_end mark (in_byte ignored
//            when body_end is set). Valid/ready handshake.
//   o_out  : zero or one result per input item: a payload byte with
//            frame_last on the final byte, or a status-only item for a frame
//            aborted at body end or dropped for oversize length.
//   i_cfg  : register writes (0 sync word, 1 max payload length), always
//            ready; write only while the block is idle.
// Throughput is one item per cycle while the output buffer has room; the
// next state for a byte is combinational. o_out is driven from registers.
// A two-entry output buffer keeps i_in ready while one result
// waits; with both entries full i_in.ready drops until o_out drains.
// Reset (synchronous, active low) restores the default sync word 0xCA6EE595,
// limit 65535, clears the buffer and restarts the hunt.
// ----------------------------------------------------------------------------
module magic_length_deframer #(
    parameter int unsigned SYNC_BYTES   = mld_pkg::DEF_SYNC_BYTES,
    parameter int unsigned LENGTH_BYTES = mld_pkg::DEF_LENGTH_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mld_in_if.sink      i_in,
    mld_out_if.source   o_out,
    mld_cfg_if.sink     i_cfg
);

    mld_pkg::t_cfg    cfg;
    mld_pkg::t_result res;
    logic             res_valid;
    logic             res_room;

    mld_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mld_core #(
        .SYNC_BYTES   (SYNC_BYTES),
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .i_res_room  (res_room),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mld_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_room  (res_room),
        .o_out   (o_out)
    );

endmodule
